### src/s2i_pkg.sv
// Shared types and constants for the custom-base string-to-integer parser.
// No dependencies; used by every module of the block.
package s2i_pkg;

  // Alphabet geometry fixed by the register map
  localparam int unsigned ALPHA_POS  = 16;
  localparam int unsigned IDX_W      = 4;
  localparam int unsigned CNT_W      = 5;
  localparam int unsigned CHAR_W     = 8;
  localparam int unsigned VALUE_W    = 32;
  localparam int unsigned CFG_DATA_W = 64;
  localparam int unsigned CFG_IDX_W  = 2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ALPHA_LOW  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ALPHA_HIGH = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BASE_LEN   = 2'd2;

  // Special characters
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
  localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
  localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
  localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
  localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;

  // Smallest usable base
  localparam logic [CNT_W-1:0] MIN_BASE = 5'd2;

  // Queue between classifier and parser
  localparam int unsigned Q_DEPTH = 2;
  localparam int unsigned Q_PTR_W = 1;
  localparam int unsigned Q_CNT_W = 2;

  // Parser phases
  typedef enum logic [1:0] {
    PH_SPACE,
    PH_SIGN,
    PH_DIGIT,
    PH_DONE
  } phase_t;

  // One classified character
  typedef struct packed {
    logic             start;     // first character of a new string
    logic             alpha_ok;  // alphabet valid (meaningful on start)
    logic             space;     // whitespace
    logic             minus;
    logic             plus;
    logic             hit;       // found in the alphabet
    logic [IDX_W-1:0] idx;       // digit index when hit
    logic [CNT_W-1:0] used;      // positions in use, the base
  } s2i_item_t;

endpackage

### src/s2i_front.sv
// Front end: configuration registers, alphabet check and character classifier.
// Depends on s2i_pkg.
module s2i_front import s2i_pkg::*; #(
  parameter int unsigned MAX_DIGITS = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_write,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic [CHAR_W-1:0]     character,
  input  logic                  start_req,
  output s2i_item_t             item
);

  logic [CFG_DATA_W-1:0] alphabet_low;
  logic [CFG_DATA_W-1:0] alphabet_high;
  logic [CNT_W-1:0]      base_length;

  logic [CHAR_W-1:0]     alpha [ALPHA_POS];
  logic [CNT_W-1:0]      used;
  logic                  base_ok;
  logic                  chars_ok;
  logic                  hit;
  logic [IDX_W-1:0]      idx;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      alphabet_low  <= '0;
      alphabet_high <= '0;
      base_length   <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_ALPHA_LOW:  alphabet_low  <= cfg_data;
        REG_ALPHA_HIGH: alphabet_high <= cfg_data;
        REG_BASE_LEN:   base_length   <= cfg_data[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  // Byte view of the alphabet
  always_comb begin
    for (int k = 0; k < ALPHA_POS / 2; k++) begin
      alpha[k]                 = alphabet_low[k*CHAR_W +: CHAR_W];
      alpha[k + ALPHA_POS / 2] = alphabet_high[k*CHAR_W +: CHAR_W];
    end
  end

  // Base clamped to the digit limit
  always_comb begin
    if ({1'b0, base_length} > (CNT_W + 1)'(MAX_DIGITS)) used = CNT_W'(MAX_DIGITS);
    else used = base_length;
    base_ok = (base_length >= MIN_BASE) &&
              ({1'b0, base_length} <= (CNT_W + 1)'(MAX_DIGITS));
  end

  // Alphabet check: no sign, space, control or repeated characters in use
  always_comb begin
    chars_ok = 1'b1;
    for (int i = 0; i < MAX_DIGITS; i++) begin
      if ((CNT_W + 1)'(i) < {1'b0, base_length}) begin
        if (alpha[i] == CH_MINUS || alpha[i] == CH_PLUS || alpha[i] == CH_NUL ||
            alpha[i] == CH_SPACE || (alpha[i] >= CH_TAB && alpha[i] <= CH_CR))
          chars_ok = 1'b0;
        for (int j = i + 1; j < MAX_DIGITS; j++) begin
          if ((CNT_W + 1)'(j) < {1'b0, base_length} && alpha[j] == alpha[i])
            chars_ok = 1'b0;
        end
      end
    end
  end

  // Digit lookup, lowest matching position wins
  always_comb begin
    hit = 1'b0;
    idx = '0;
    for (int k = MAX_DIGITS - 1; k >= 0; k--) begin
      if ((CNT_W + 1)'(k) < {1'b0, used} && alpha[k] == character) begin
        hit = 1'b1;
        idx = IDX_W'(k);
      end
    end
  end

  // Classified item
  always_comb begin
    item.start    = start_req;
    item.alpha_ok = base_ok && chars_ok;
    item.space    = (character == CH_SPACE) ||
                    (character >= CH_TAB && character <= CH_CR);
    item.minus    = (character == CH_MINUS);
    item.plus     = (character == CH_PLUS);
    item.hit      = hit;
    item.idx      = idx;
    item.used     = used;
  end

endmodule

### src/s2i_queue.sv
// Two-entry queue of classified characters between front end and parser.
// Depends on s2i_pkg.
module s2i_queue import s2i_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  s2i_item_t push_item,
  output logic      full,
  input  logic      pop,
  output logic      q_valid,
  output s2i_item_t q_item
);

  s2i_item_t          mem [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr;
  logic [Q_PTR_W-1:0] rd_ptr;
  logic [Q_CNT_W-1:0] count;

  // Storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_item;
    end
  end

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      case ({push, pop})
        2'b10:   count <= count + Q_CNT_W'(1);
        2'b01:   count <= count - Q_CNT_W'(1);
        default: ;
      endcase
    end
  end

  assign full    = (count == Q_CNT_W'(Q_DEPTH));
  assign q_valid = (count != '0);
  assign q_item  = mem[rd_ptr];

endmodule

### src/s2i_back.sv
// Back end: parse state machine, multiply-add accumulator and output register.
// Depends on s2i_pkg.
module s2i_back import s2i_pkg::*; (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      q_valid,
  input  s2i_item_t                 q_item,
  output logic                      pop,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic signed [VALUE_W-1:0] value,
  output logic                      alphabet_ok
);

  phase_t             phase;
  phase_t             phase_next;
  phase_t             eff_phase;
  logic               negative;
  logic               negative_next;
  logic [VALUE_W-1:0] accumulator;
  logic [VALUE_W-1:0] accumulator_next;
  logic [VALUE_W-1:0] acc_base;
  logic               neg_base;
  logic               sign_region;
  logic               emit;
  logic               emit_ok;
  logic [VALUE_W-1:0] emit_value;

  // Take an item whenever the output slot is free or draining
  assign pop = q_valid && (!out_valid || out_ready);

  // Phase seen by this item after a start has been applied
  always_comb begin
    if (q_item.start) eff_phase = q_item.alpha_ok ? PH_SPACE : PH_DONE;
    else eff_phase = phase;
    acc_base    = q_item.start ? '0 : accumulator;
    neg_base    = q_item.start ? 1'b0 : negative;
    sign_region = (eff_phase == PH_SIGN) || (eff_phase == PH_SPACE && !q_item.space);
  end

  // Next phase
  always_comb begin
    phase_next = phase;
    if (pop) begin
      unique case (eff_phase) inside
        PH_SPACE, PH_SIGN: begin
          if (eff_phase == PH_SPACE && q_item.space) phase_next = PH_SPACE;
          else if (q_item.minus || q_item.plus)      phase_next = PH_SIGN;
          else if (q_item.hit)                       phase_next = PH_DIGIT;
          else                                       phase_next = PH_DONE;
        end
        PH_DIGIT: phase_next = q_item.hit ? PH_DIGIT : PH_DONE;
        PH_DONE:  phase_next = PH_DONE;
        default:  phase_next = PH_DONE;
      endcase
    end
  end

  // Sign, accumulator and result
  always_comb begin
    negative_next    = negative;
    accumulator_next = accumulator;
    emit             = 1'b0;
    emit_ok          = 1'b1;
    emit_value       = neg_base ? (VALUE_W'(0) - acc_base) : acc_base;
    if (pop) begin
      negative_next    = neg_base;
      accumulator_next = acc_base;
      if (q_item.start && !q_item.alpha_ok) begin
        emit       = 1'b1;
        emit_ok    = 1'b0;
        emit_value = '0;
      end else if (sign_region && (q_item.minus || q_item.plus)) begin
        negative_next = neg_base ^ q_item.minus;
      end else if ((sign_region || eff_phase == PH_DIGIT) && q_item.hit) begin
        accumulator_next = VALUE_W'(acc_base * {{(VALUE_W - CNT_W){1'b0}}, q_item.used})
                           + {{(VALUE_W - IDX_W){1'b0}}, q_item.idx};
      end else if (sign_region || eff_phase == PH_DIGIT) begin
        emit = 1'b1;
      end
    end
  end

  // Parse state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_DONE;
      negative    <= 1'b0;
      accumulator <= '0;
    end else begin
      phase       <= phase_next;
      negative    <= negative_next;
      accumulator <= accumulator_next;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      value       <= emit_value;
      alphabet_ok <= emit_ok;
    end
  end

endmodule

### src/string_to_int_custom_base.sv
// Top level of the custom-base string-to-integer parser.
// Depends on s2i_pkg, s2i_front, s2i_queue and s2i_back.
//
//   channel  signals                                  direction  transfer when
//   cfg      cfg_valid cfg_ready cfg_index cfg_data   in         cfg_valid & cfg_ready
//   in       in_valid in_ready character start_req    in         in_valid & in_ready
//   out      out_valid out_ready value alphabet_ok    out        out_valid & out_ready
//
// One character per cycle while in_ready is high. A character is classified in the cycle
// it is accepted and written into the queue; the parser then takes it from the queue,
// and the result of a finished string is registered in the output register. The
// multiply-add of the parser sets the cycle time. Reset empties the queue and puts the
// parser in its waiting state; cfg_ready is always high. A stalled output holds the
// parser, and the queue fills and then drops in_ready.
module string_to_int_custom_base import s2i_pkg::*; #(
  parameter int unsigned MAX_DIGITS = 16
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [CFG_IDX_W-1:0]      cfg_index,
  input  logic [CFG_DATA_W-1:0]     cfg_data,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [CHAR_W-1:0]         character,
  input  logic                      start_req,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic signed [VALUE_W-1:0] value,
  output logic                      alphabet_ok
);

  s2i_item_t front_item;
  s2i_item_t q_item;
  logic      q_full;
  logic      q_valid;
  logic      q_pop;
  logic      push;

  assign cfg_ready = 1'b1;
  assign in_ready  = !q_full;
  assign push      = in_valid && in_ready;

  s2i_front #(
    .MAX_DIGITS (MAX_DIGITS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .character (character),
    .start_req (start_req),
    .item      (front_item)
  );

  s2i_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (front_item),
    .full      (q_full),
    .pop       (q_pop),
    .q_valid   (q_valid),
    .q_item    (q_item)
  );

  s2i_back u_back (
    .clk         (clk),
    .rst         (rst),
    .q_valid     (q_valid),
    .q_item      (q_item),
    .pop         (q_pop),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .value       (value),
    .alphabet_ok (alphabet_ok)
  );

  // A rejected alphabet always reports zero
  a_reject_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !alphabet_ok |-> value == '0)
    else $error("rejected alphabet with nonzero value");

  // Queue is empty right after reset
  a_ready_after_reset: assert property (@(posedge clk)
    $past(rst) |-> in_ready)
    else $error("in_ready low after reset");

  // An accepted character is queued for the parser
  a_push_queued: assert property (@(posedge clk) disable iff (rst)
    push |=> q_valid)
    else $error("accepted character missing from queue");

endmodule

### tb/s2i_parse_checker.sv
// Checker for the custom-base string-to-integer parser: watches all three channels,
// predicts every result and compares it with what the block delivers.
// Depends on s2i_pkg for widths, register indexes, special characters and phases.
module s2i_parse_checker import s2i_pkg::*; #(
  parameter int unsigned MAX_DIGITS = 16
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_valid,
  input  logic                      cfg_ready,
  input  logic [CFG_IDX_W-1:0]      cfg_index,
  input  logic [CFG_DATA_W-1:0]     cfg_data,
  input  logic                      in_valid,
  input  logic                      in_ready,
  input  logic [CHAR_W-1:0]         character,
  input  logic                      start_req,
  input  logic                      out_valid,
  input  logic                      out_ready,
  input  logic signed [VALUE_W-1:0] value,
  input  logic                      alphabet_ok,
  output int unsigned               mismatches,
  output int unsigned               outstanding
);

  typedef struct packed {
    logic [VALUE_W-1:0] val;
    logic               ok;
  } parsed_number_t;

  // Shadow registers
  logic [CFG_DATA_W-1:0] alpha_lo;
  logic [CFG_DATA_W-1:0] alpha_hi;
  logic [CNT_W-1:0]      base_count;

  // Parser state
  phase_t               parse_phase;
  logic                 negative;
  logic [VALUE_W-1:0]   acc;

  parsed_number_t expected_numbers[$];
  parsed_number_t head;
  int unsigned    fail_count;

  function automatic logic [CHAR_W-1:0] digit_char(input int unsigned k);
    logic [CFG_DATA_W-1:0] word;
    word = (k < 8) ? alpha_lo : alpha_hi;
    return word[8*(k%8) +: 8];
  endfunction

  // Positions searched for digits; the base is clamped to the alphabet size
  function automatic int unsigned digits_in_use();
    int unsigned n;
    n = 32'(base_count);
    if (n > MAX_DIGITS) n = MAX_DIGITS;
    if (n > ALPHA_POS) n = ALPHA_POS;
    return n;
  endfunction

  function automatic bit is_blank(input logic [CHAR_W-1:0] c);
    return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
  endfunction

  // Checked only when a string starts
  function automatic bit alphabet_usable();
    logic [CHAR_W-1:0] c;
    int unsigned       b;
    b = 32'(base_count);
    if (base_count < MIN_BASE || b > MAX_DIGITS) return 1'b0;
    for (int unsigned i = 0; i < b; i++) begin
      c = digit_char(i);
      if (c == CH_MINUS || c == CH_PLUS || c == CH_NUL || is_blank(c)) return 1'b0;
      for (int unsigned j = i + 1; j < b; j++)
        if (digit_char(j) == c) return 1'b0;
    end
    return 1'b1;
  endfunction

  // Lowest matching position wins
  function automatic bit digit_index(input logic [CHAR_W-1:0] c, output int unsigned idx);
    int unsigned n;
    n = digits_in_use();
    idx = 0;
    for (int unsigned k = 0; k < n; k++) begin
      if (digit_char(k) == c) begin
        idx = k;
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  // One character through the parser; a finished string queues its number
  function automatic void advance_parse(input logic [CHAR_W-1:0] c, input logic st);
    int unsigned        idx;
    logic [VALUE_W-1:0] result;
    if (st) begin
      negative = 1'b0;
      acc = '0;
      if (!alphabet_usable()) begin
        parse_phase = PH_DONE;
        expected_numbers.push_back('{val: '0, ok: 1'b0});
        return;
      end
      parse_phase = PH_SPACE;
    end
    if (parse_phase == PH_DONE) return;
    if (parse_phase == PH_SPACE) begin
      if (is_blank(c)) return;
      parse_phase = PH_SIGN;
    end
    if (parse_phase == PH_SIGN) begin
      if (c == CH_MINUS) begin
        negative = ~negative;
        return;
      end
      if (c == CH_PLUS) return;
      parse_phase = PH_DIGIT;
    end
    if (digit_index(c, idx)) begin
      acc = acc * VALUE_W'(digits_in_use()) + VALUE_W'(idx);
      return;
    end
    parse_phase = PH_DONE;
    result = negative ? -acc : acc;
    expected_numbers.push_back('{val: result, ok: 1'b1});
  endfunction

  function automatic void note_failure(input parsed_number_t want, input bit have_want);
    if (fail_count < 10) begin
      if (have_want)
        $display("%0t: mismatch: expected value %0d ok %0b, got value %0d ok %0b",
                 $time, $signed(want.val), want.ok, value, alphabet_ok);
      else
        $display("%0t: result with nothing pending: value %0d ok %0b",
                 $time, value, alphabet_ok);
    end
    fail_count++;
  endfunction

  // Compare results, predict from accepted characters, then track registers;
  // a character taken on the same edge as a write still sees the old setting
  always @(posedge clk) begin
    if (rst) begin
      alpha_lo = '0;
      alpha_hi = '0;
      base_count = '0;
      parse_phase = PH_DONE;
      negative = 1'b0;
      acc = '0;
      expected_numbers.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (expected_numbers.size() == 0) begin
          note_failure('0, 1'b0);
        end else begin
          head = expected_numbers.pop_front();
          if (head.val !== value || head.ok !== alphabet_ok) note_failure(head, 1'b1);
        end
      end
      if (in_valid && in_ready) advance_parse(character, start_req);
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_ALPHA_LOW:  alpha_lo = cfg_data;
          REG_ALPHA_HIGH: alpha_hi = cfg_data;
          REG_BASE_LEN:   base_count = cfg_data[CNT_W-1:0];
          default: ;
        endcase
      end
    end
    outstanding <= expected_numbers.size();
    mismatches  <= fail_count;
  end

  initial fail_count = 0;

endmodule

### tb/string_to_int_custom_base_tb.sv
// Testbench top for string_to_int_custom_base: clock, reset, register writes and
// character stimulus with random idling. Depends on s2i_pkg and s2i_parse_checker.
module string_to_int_custom_base_tb;
  import s2i_pkg::*;

  localparam int unsigned NUM_ITEMS    = 1400;
  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam int unsigned DRAIN_CYCLES = 6;

  typedef enum int {
    BAD_SHORT, BAD_LONG, BAD_DUP, BAD_PLUS, BAD_MINUS, BAD_SPACE, BAD_NUL, BAD_CTRL
  } alpha_defect_t;

  logic                      clk = 1'b0;
  logic                      rst;
  logic                      cfg_valid;
  logic                      cfg_ready;
  logic [CFG_IDX_W-1:0]      cfg_index;
  logic [CFG_DATA_W-1:0]     cfg_data;
  logic                      in_valid;
  logic                      in_ready;
  logic [CHAR_W-1:0]         character;
  logic                      start_req;
  logic                      out_valid;
  logic                      out_ready = 1'b0;
  logic signed [VALUE_W-1:0] value;
  logic                      alphabet_ok;
  int unsigned               mismatches;
  int unsigned               outstanding;

  // Stimulus-side copy of the alphabet, used to pick digits
  logic [CHAR_W-1:0] alpha [ALPHA_POS];
  int unsigned       base;
  int unsigned       items_sent;
  int unsigned       cycle_count;
  int unsigned       phase_no;
  int unsigned       phase_end;
  int unsigned       pick;
  bit                quiet;
  bit                sender_gaps;
  bit                sink_stalls;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  string_to_int_custom_base i_dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .character   (character),
    .start_req   (start_req),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .value       (value),
    .alphabet_ok (alphabet_ok)
  );

  s2i_parse_checker u_checker (
    .clk         (clk),
    .rst         (rst),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .character   (character),
    .start_req   (start_req),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .value       (value),
    .alphabet_ok (alphabet_ok),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  // Result side: random stall bursts
  always begin
    @(posedge clk);
    if (sink_stalls && !quiet && $urandom_range(0, 4) == 0) begin
      out_ready <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    out_ready <= 1'b1;
  end

  function automatic logic [CHAR_W-1:0] random_byte();
    return CHAR_W'($urandom_range(0, 255));
  endfunction

  // One character transfer, maybe after an idle burst
  task automatic push_char(input logic [CHAR_W-1:0] c, input logic st);
    if (sender_gaps && !quiet && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_valid  <= 1'b1;
    character <= c;
    start_req <= st;
    do @(posedge clk); while (!in_ready);
    items_sent++;
  endtask

  task automatic feed(input string s, input bit start_first);
    for (int i = 0; i < s.len(); i++) push_char(s[i], start_first && i == 0);
  endtask

  // Hold off until every pending number is out and the pipeline is empty
  task automatic settle();
    in_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] d);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic apply_alphabet();
    logic [CFG_DATA_W-1:0] lo;
    logic [CFG_DATA_W-1:0] hi;
    for (int k = 0; k < 8; k++) begin
      lo[8*k +: 8] = alpha[k];
      hi[8*k +: 8] = alpha[k+8];
    end
    settle();
    write_reg(REG_ALPHA_LOW, lo);
    write_reg(REG_ALPHA_HIGH, hi);
    write_reg(REG_BASE_LEN, CFG_DATA_W'(base));
    cfg_valid <= 1'b0;
  endtask

  function automatic void load_alphabet(input string s);
    base = s.len();
    for (int k = 0; k < ALPHA_POS; k++) alpha[k] = (k < s.len()) ? s[k] : CH_NUL;
  endfunction

  function automatic bit reserved_char(input logic [CHAR_W-1:0] c);
    return c == CH_NUL || c == CH_PLUS || c == CH_MINUS || c == CH_SPACE ||
           (c >= CH_TAB && c <= CH_CR);
  endfunction

  function automatic bit taken(input logic [CHAR_W-1:0] c, input int unsigned upto);
    for (int k = 0; k < upto; k++) if (alpha[k] == c) return 1'b1;
    return 1'b0;
  endfunction

  function automatic int unsigned used_digits();
    return (base > ALPHA_POS) ? ALPHA_POS : base;
  endfunction

  // Distinct legal digits in use, junk in the unused positions
  function automatic void random_alphabet(input int unsigned b);
    base = b;
    for (int k = 0; k < ALPHA_POS; k++) begin
      if (k < b) begin
        do alpha[k] = random_byte();
        while (reserved_char(alpha[k]) || taken(alpha[k], k));
      end else begin
        alpha[k] = random_byte();
      end
    end
  endfunction

  function automatic void broken_alphabet();
    alpha_defect_t defect;
    int unsigned   i;
    int unsigned   j;
    defect = alpha_defect_t'($urandom_range(0, 7));
    random_alphabet($urandom_range(2, ALPHA_POS));
    i = $urandom_range(0, base - 1);
    case (defect)
      BAD_SHORT: base = $urandom_range(0, 1);
      BAD_LONG:  base = $urandom_range(ALPHA_POS + 1, 31);
      BAD_DUP: begin
        i = $urandom_range(0, base - 2);
        j = $urandom_range(i + 1, base - 1);
        alpha[j] = alpha[i];
      end
      BAD_PLUS:  alpha[i] = CH_PLUS;
      BAD_MINUS: alpha[i] = CH_MINUS;
      BAD_SPACE: alpha[i] = CH_SPACE;
      BAD_NUL:   alpha[i] = CH_NUL;
      default:   alpha[i] = CHAR_W'($urandom_range(CH_TAB, CH_CR));
    endcase
  endfunction

  function automatic logic [CHAR_W-1:0] blank_char();
    int unsigned k;
    k = $urandom_range(0, 5);
    return (k == 5) ? CH_SPACE : CH_TAB + CHAR_W'(k);
  endfunction

  // Well-formed number: blanks, signs, digits, then a terminator unless left open
  task automatic send_number(input bit terminate);
    logic [CHAR_W-1:0] chars[$];
    logic [CHAR_W-1:0] t;
    int unsigned       n_dig;
    repeat ($urandom_range(0, 3)) chars.push_back(blank_char());
    repeat ($urandom_range(0, 3)) chars.push_back($urandom_range(0, 1) ? CH_MINUS : CH_PLUS);
    n_dig = ($urandom_range(0, 7) == 0) ? $urandom_range(11, 40) : $urandom_range(0, 10);
    repeat (n_dig) chars.push_back(alpha[$urandom_range(0, used_digits() - 1)]);
    if (terminate || chars.size() == 0) begin
      if ($urandom_range(0, 1)) t = CH_NUL;
      else do t = random_byte(); while (taken(t, used_digits()));
      chars.push_back(t);
    end
    foreach (chars[i]) push_char(chars[i], i == 0);
  endtask

  // Run limit
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("tb: failure");
    $finish;
  end

  initial begin
    rst         <= 1'b1;
    in_valid    <= 1'b0;
    character   <= CH_NUL;
    start_req   <= 1'b0;
    cfg_valid   <= 1'b0;
    cfg_index   <= REG_ALPHA_LOW;
    cfg_data    <= '0;
    quiet       = 1'b0;
    sender_gaps = 1'b1;
    sink_stalls = 1'b1;
    items_sent  = 0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Ignored while waiting, then a start against the reset registers (base 0)
    push_char("A", 1'b0);
    push_char("5", 1'b1);

    // Blanks, repeated signs cancelling out
    load_alphabet("0123456789");
    apply_alphabet();
    feed("\t-+-99", 1'b1);
    push_char(CH_NUL, 1'b0);

    // A new start abandons the open string
    feed(" -5", 1'b1);
    feed("3x", 1'b1);

    // Registers rewritten mid-string: oversized base clamps, repeated digit takes lowest
    feed("12", 1'b1);
    load_alphabet("0120120120120120");
    base = 20;
    apply_alphabet();
    push_char("2", 1'b0);
    push_char(CH_NUL, 1'b0);

    // Base 16 with extreme byte values; wraps past 32 bits, then negated
    for (int k = 0; k < ALPHA_POS; k++) alpha[k] = 8'h41 + k;
    alpha[0]  = 8'h01;
    alpha[8]  = 8'h80;
    alpha[15] = 8'hFF;
    base = ALPHA_POS;
    apply_alphabet();
    push_char(CH_MINUS, 1'b1);
    repeat (9) push_char(8'hFF, 1'b0);
    push_char(8'h80, 1'b0);
    push_char(CH_NUL, 1'b0);

    // Rejected alphabets
    load_alphabet("0123456789");
    base = 1;
    apply_alphabet();
    push_char("1", 1'b1);
    base = ALPHA_POS + 1;
    apply_alphabet();
    push_char("1", 1'b1);
    load_alphabet("0123456720");
    apply_alphabet();
    push_char("1", 1'b1);
    load_alphabet("01234+6789");
    apply_alphabet();
    push_char("1", 1'b1);

    // Random phases, each with its own register setting
    phase_no = 0;
    while (items_sent < NUM_ITEMS) begin
      if (NUM_ITEMS - items_sent < 250) quiet = 1'b1;
      sender_gaps = $urandom_range(0, 4) != 0;
      sink_stalls = $urandom_range(0, 4) != 0;
      if (phase_no % 5 == 4) begin
        broken_alphabet();
        apply_alphabet();
        // An open string may carry on under the new setting
        repeat ($urandom_range(0, 2)) push_char(random_byte(), 1'b0);
        repeat (6) begin
          push_char(random_byte(), 1'b1);
          if ($urandom_range(0, 1)) push_char(random_byte(), 1'b0);
        end
      end else begin
        if (phase_no == 0) random_alphabet(2);
        else if (phase_no == 1) random_alphabet(ALPHA_POS);
        else random_alphabet($urandom_range(2, ALPHA_POS));
        apply_alphabet();
        repeat ($urandom_range(0, 2))
          push_char($urandom_range(0, 1) ? alpha[$urandom_range(0, base - 1)]
                                         : random_byte(), 1'b0);
        phase_end = items_sent + $urandom_range(120, 220);
        while (items_sent < phase_end && items_sent < NUM_ITEMS) begin
          pick = $urandom_range(0, 19);
          if (pick < 15) begin
            send_number(1'b1);
          end else if (pick < 17) begin
            send_number(1'b0);
          end else begin
            // Noise: random bytes, some of them starts
            repeat ($urandom_range(1, 4)) begin
              if ($urandom_range(0, 3) == 0) begin
                push_char(random_byte(), 1'b1);
              end else begin
                push_char(random_byte(), 1'b0);
              end
            end
          end
        end
      end
      phase_no++;
    end

    settle();
    if (mismatches == 0 && outstanding == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule
